// File: rtl/apmc_pkg.sv
// apmc_pkg: shared types and constants of the approximate pattern matcher
// used by apmc_cell and approx_pattern_match_cutoff_unit; no dependencies
package apmc_pkg;

    localparam int SYM_W   = 8;   // pattern and text symbol
    localparam int DIST_W  = 7;   // stored column entry
    localparam int CUR_W   = 8;   // running value handed down the chain
    localparam int ERR_W   = 6;   // max_errors and reported distance
    localparam int PLEN_W  = 7;   // pattern_length register
    localparam int PIDX_W  = 6;   // pattern_index field
    localparam int POS_W   = 32;  // text position
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PIDX_W-1:0] pattern_index;
        logic [SYM_W-1:0]  symbol;
    } apmc_in_t;

    typedef struct packed {
        logic [POS_W-1:0] end_position;
        logic [ERR_W-1:0] distance;
    } apmc_out_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              load;
        logic [PIDX_W-1:0] load_index;
        logic              clear;
        logic [SYM_W-1:0]  symbol;
        logic [ERR_W-1:0]  max_errors;
    } apmc_bcast_t;

    // handoff from one cell to the next
    typedef struct packed {
        logic              tok;
        logic [DIST_W-1:0] above;
        logic [CUR_W-1:0]  cur;
    } apmc_wave_t;

    // per-cell report, all zero unless the cell updates this cycle
    typedef struct packed {
        logic             hit;
        logic             in_limit;
        logic [ERR_W-1:0] row_dist;
    } apmc_rpt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } apmc_state_t;

endpackage

// File: rtl/apmc_cell.sv
// apmc_cell: one row of the edit-distance column with its pattern symbol
// depends on apmc_pkg
module apmc_cell
    import apmc_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int IDX         = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  apmc_bcast_t                          bcast,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]     last,
    input  apmc_wave_t                           wave_in,
    output apmc_wave_t                           wave_out,
    output apmc_rpt_t                            rpt
);

    localparam logic [DIST_W-1:0] INIT_DIST = DIST_W'(IDX + 1);

    logic [SYM_W-1:0]  pat_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              tok_reg;
    logic [DIST_W-1:0] above_reg;
    logic [CUR_W-1:0]  cur_reg;

    logic              fire;
    logic              load_hit;
    logic [CUR_W-1:0]  min_v;
    logic [CUR_W-1:0]  nv;

    assign fire     = wave_in.tok && (IDX < int'(last));
    assign load_hit = bcast.load && (int'(bcast.load_index) == IDX);

    always_comb begin
        min_v = wave_in.cur;
        if ({1'b0, wave_in.above} < min_v) begin
            min_v = {1'b0, wave_in.above};
        end
        if ({1'b0, dist_reg} < min_v) begin
            min_v = {1'b0, dist_reg};
        end
        if (pat_reg == bcast.symbol) begin
            nv = {1'b0, wave_in.above};
        end else begin
            nv = min_v + CUR_W'(1);
        end
    end

    // pattern slot, undefined until loaded
    always_ff @(posedge aclk) begin
        if (load_hit) begin
            pat_reg <= bcast.symbol;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || bcast.clear) begin
            dist_reg <= INIT_DIST;
        end else if (fire) begin
            dist_reg <= nv[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            above_reg <= dist_reg;
            cur_reg   <= nv;
        end
    end

    assign wave_out.tok   = tok_reg;
    assign wave_out.above = above_reg;
    assign wave_out.cur   = cur_reg;

    assign rpt.hit      = fire;
    assign rpt.in_limit = fire && (nv[DIST_W-1:0] <= {1'b0, bcast.max_errors});
    assign rpt.row_dist = fire ? nv[ERR_W-1:0] : '0;

endmodule

// File: rtl/approx_pattern_match_cutoff_unit.sv
// approx_pattern_match_cutoff_unit: top level, controller and row of apmc_cell
// depends on apmc_pkg and apmc_cell
//
// usage
//   s_ channel: one item per handshake; command load writes pattern slot
//   pattern_index, start clears the column and text position, text feeds one
//   byte of text. m_ channel: one item (end_position, distance) for each text
//   byte where the whole pattern fits within max_errors edits.
//   config port: cfg_we writes cfg_index 0 (max_errors) or 1 (pattern_length);
//   write only while the block is idle.
// timing
//   load and start complete at the edge that accepts them. a text item walks
//   down the cell row, one row per cycle, over the active rows
//   (1..pattern_length after cutoff), then passes the finishing state; after
//   that s_ready is back and the result, if any, is on m_.
// reset and stall
//   aresetn (sync, low) sets max_errors 1, pattern_length 1, column row i to
//   i+1, position 0, one active row; pattern slots stay undefined until loaded.
//   loads and starts are taken while a result waits on m_; a text item whose
//   result finds the output register still full holds in the finishing cycle.
module approx_pattern_match_cutoff_unit
    import apmc_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // item input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  apmc_in_t              s_data,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output apmc_out_t             m_data,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ROW_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // control state
    apmc_state_t        state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;       // row updated this sweep cycle
    logic [CNT_W-1:0]   last_reg, last_next;     // rows swept for this item
    logic [CNT_W-1:0]   cnt_reg, cnt_next;       // deepest row within the limit
    logic [CNT_W-1:0]   active_rows_reg, active_rows_next;
    logic               go_reg, go_next;
    logic [POS_W-1:0]   text_pos_reg, text_pos_next;
    logic [ERR_W-1:0]   max_errors_reg;
    logic [PLEN_W-1:0]  pattern_length_reg;
    logic               m_valid_reg, m_valid_next;
    // payload
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [ERR_W-1:0]   dist_reg, dist_next;
    apmc_out_t          m_data_reg, m_data_next;

    logic               accept;
    logic [CNT_W-1:0]   eff_len;
    logic [CNT_W-1:0]   start_rows;
    logic [CNT_W-1:0]   text_last;
    logic               row_at_end;
    logic               match;
    logic               room;

    apmc_bcast_t        bcast;
    apmc_wave_t         wave_head;
    apmc_wave_t         wave_out [MAX_PATTERN];
    apmc_rpt_t          rpt      [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit_vec;
    logic               any_within;
    logic [ERR_W-1:0]   any_dist;

    assign accept = s_valid && s_ready;

    // pattern length clamped to 1..MAX_PATTERN
    always_comb begin
        if (pattern_length_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if (int'(pattern_length_reg) > MAX_PATTERN) begin
            eff_len = CNT_W'(MAX_PATTERN);
        end else begin
            eff_len = CNT_W'(pattern_length_reg);
        end
    end

    // rows active after a start: max_errors + 1, at most the pattern length
    always_comb begin
        if (int'(max_errors_reg) + 1 > int'(eff_len)) begin
            start_rows = eff_len;
        end else begin
            start_rows = CNT_W'(int'(max_errors_reg) + 1);
        end
    end

    // rows swept for a text byte, kept within 1..pattern length
    always_comb begin
        if (active_rows_reg == '0) begin
            text_last = CNT_W'(1);
        end else if (active_rows_reg > eff_len) begin
            text_last = eff_len;
        end else begin
            text_last = active_rows_reg;
        end
    end

    assign row_at_end = (CNT_W'(row_reg) == last_reg - CNT_W'(1));
    assign match      = (cnt_reg == eff_len);
    assign room       = !m_valid_reg || m_ready;

    // cell row
    assign wave_head.tok   = go_reg;
    assign wave_head.above = '0;
    assign wave_head.cur   = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            if (g == 0) begin : g_head
                apmc_cell #(
                    .MAX_PATTERN (MAX_PATTERN),
                    .IDX         (g)
                ) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .bcast    (bcast),
                    .last     (last_reg),
                    .wave_in  (wave_head),
                    .wave_out (wave_out[g]),
                    .rpt      (rpt[g])
                );
            end else begin : g_body
                apmc_cell #(
                    .MAX_PATTERN (MAX_PATTERN),
                    .IDX         (g)
                ) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .bcast    (bcast),
                    .last     (last_reg),
                    .wave_in  (wave_out[g-1]),
                    .wave_out (wave_out[g]),
                    .rpt      (rpt[g])
                );
            end
            assign hit_vec[g] = rpt[g].hit;
        end
    endgenerate

    // only the cell at the wavefront reports, so an or gathers its flags
    always_comb begin
        any_within = 1'b0;
        any_dist   = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            any_within = any_within | rpt[i].in_limit;
            any_dist   = any_dist | rpt[i].row_dist;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.command == CMD_TEXT) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (row_at_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // a match waits here until the output register is free
                if (!match || room) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready          = 1'b0;
        row_next         = row_reg;
        last_next        = last_reg;
        cnt_next         = cnt_reg;
        active_rows_next = active_rows_reg;
        go_next          = 1'b0;
        text_pos_next    = text_pos_reg;
        sym_next         = sym_reg;
        dist_next        = dist_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;

        bcast.load       = 1'b0;
        bcast.load_index = s_data.pattern_index;
        bcast.clear      = 1'b0;
        bcast.symbol     = sym_reg;
        bcast.max_errors = max_errors_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.command)
                        CMD_LOAD: begin
                            bcast.load   = 1'b1;
                            bcast.symbol = s_data.symbol;
                        end
                        CMD_START: begin
                            bcast.clear      = 1'b1;
                            text_pos_next    = '0;
                            active_rows_next = start_rows;
                        end
                        CMD_TEXT: begin
                            last_next     = text_last;
                            text_pos_next = text_pos_reg + POS_W'(1);
                            sym_next      = s_data.symbol;
                            go_next       = 1'b1;
                            row_next      = '0;
                            cnt_next      = '0;
                        end
                        default: begin
                            // unknown command is dropped
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (any_within) begin
                    cnt_next = CNT_W'(row_reg) + CNT_W'(1);
                end
                if (row_at_end) begin
                    dist_next = any_dist;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ST_FINISH: begin
                if (match) begin
                    if (room) begin
                        m_valid_next             = 1'b1;
                        m_data_next.end_position = text_pos_reg;
                        m_data_next.distance     = dist_reg;
                        active_rows_next         = eff_len;
                    end
                end else begin
                    active_rows_next = cnt_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            row_reg         <= '0;
            last_reg        <= CNT_W'(1);
            cnt_reg         <= '0;
            active_rows_reg <= CNT_W'(1);
            go_reg          <= 1'b0;
            text_pos_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            last_reg        <= last_next;
            cnt_reg         <= cnt_next;
            active_rows_reg <= active_rows_next;
            go_reg          <= go_next;
            text_pos_reg    <= text_pos_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg    <= sym_next;
        dist_reg   <= dist_next;
        m_data_reg <= m_data_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_errors_reg     <= ERR_W'(1);
            pattern_length_reg <= PLEN_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_ERRORS: begin
                    max_errors_reg <= cfg_wdata[ERR_W-1:0];
                end
                REG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wdata[PLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // during a sweep exactly the addressed row updates, and none otherwise
    a_wavefront: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> ($onehot(hit_vec) && hit_vec[row_reg]))
        else $error("wavefront not at the addressed row");

    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SWEEP) |-> (hit_vec == '0))
        else $error("cell updated outside a sweep");

    // swept rows stay within the pattern
    a_last_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (last_reg != '0 && last_reg <= eff_len))
        else $error("row count out of range during sweep");

    a_active_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        active_rows_reg != '0)
        else $error("active row count fell to zero");

    // a new result comes only out of a finished match
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH && $past(match)))
        else $error("result raised without a match");

    // the wave never runs past the bottom of the row
    a_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        wave_out[MAX_PATTERN-1].tok |-> (state_reg == ST_FINISH))
        else $error("wave left the last cell outside the finishing cycle");
`endif

endmodule

// File: sim/approx_pattern_match_cutoff_unit_tb.sv
// approx_pattern_match_cutoff_unit_tb: self-checking bench for the approximate pattern matcher
// streams loads, scan starts and text bytes, predicts every match and compares it field by field
// depends on apmc_pkg and approx_pattern_match_cutoff_unit
module approx_pattern_match_cutoff_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import apmc_pkg::*;

    localparam int MAX_PAT       = 64;
    // margin exceeds the row walk of the longest text item, so this covers any item still in flight
    localparam int SETTLE_CYCLES = MAX_PAT + 16;
    localparam int LIMIT_CYCLES  = 800_000;
    localparam int RANDOM_ITEMS  = 950;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20_000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one row of the directed table: a register write or an item, with an optional typed result
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        apmc_in_t              item;
        logic                  typed;
        apmc_out_t             want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    apmc_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    apmc_out_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // idling control shared by both sides
    bit no_idle  = 1'b0;   // phase with no gaps and no stalls
    bit hold_req = 1'b0;   // asks the result side for one long hold-off

    int err_cnt        = 0;
    int items_sent     = 0;
    int random_items   = 0;
    int reg_writes     = 0;
    int matches_seen   = 0;
    int predicted_hits = 0;
    int cycle_cnt      = 0;

    // symbol set used to build text in the current phase
    logic [SYM_W-1:0] alpha [4];
    bit               narrow_alpha = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    approx_pattern_match_cutoff_unit #(
        .MAX_PATTERN(MAX_PAT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // predictor: own copy of the pattern, the distance column and config
    // ------------------------------------------------------------------
    logic [SYM_W-1:0]  pat_mem  [MAX_PAT];
    logic [DIST_W-1:0] dist_col [MAX_PAT];
    logic [PLEN_W-1:0] live_rows;
    logic [POS_W-1:0]  text_pos;
    logic [ERR_W-1:0]  lim_errors;
    logic [PLEN_W-1:0] plen_reg;
    apmc_out_t         pending_matches [$];

    // pattern length in use, clamped to 1..MAX_PAT
    function automatic int unsigned used_length();
        int unsigned m;
        m = plen_reg;
        if (m < 1) m = 1;
        if (m > MAX_PAT) m = MAX_PAT;
        return m;
    endfunction

    // new scan: row i back to i+1, position zero, active rows from the error limit
    task automatic clear_column();
        int unsigned lim;
        lim = lim_errors + 1;
        for (int i = 0; i < MAX_PAT; i++) dist_col[i] = DIST_W'(i + 1);
        text_pos = '0;
        if (lim > used_length()) lim = used_length();
        live_rows = PLEN_W'(lim);
    endtask

    // applies one accepted item; a text byte may queue one expected match
    task automatic update_edit_column(input apmc_in_t it);
        int unsigned m, last, cnt, above, cur, old, nv;
        apmc_out_t   hit;
        case (it.command)
            CMD_LOAD: begin
                if (it.pattern_index < MAX_PAT) pat_mem[it.pattern_index] = it.symbol;
            end
            CMD_START: begin
                clear_column();
            end
            CMD_TEXT: begin
                m = used_length();
                // active rows clamped to 1..m first, covers writes made mid-scan
                last = live_rows;
                if (last < 1) last = 1;
                if (last > m) last = m;
                text_pos = text_pos + 1'b1;
                // row above row 0 is the constant zero, old and new
                above = 0;
                cur   = 0;
                for (int i = 0; i < last; i++) begin
                    old = dist_col[i];
                    if (pat_mem[i] == it.symbol) begin
                        nv = above;
                    end else begin
                        nv = cur;
                        if (above < nv) nv = above;
                        if (old < nv) nv = old;
                        nv = nv + 1;
                    end
                    above = old;
                    cur   = nv;
                    dist_col[i] = DIST_W'(nv);
                end
                // cutoff: drop trailing rows over the limit, may reach zero
                cnt = last;
                while (cnt > 0 && dist_col[cnt-1] > lim_errors) cnt--;
                if (cnt == m) begin
                    live_rows        = PLEN_W'(m);
                    hit.end_position = text_pos;
                    hit.distance     = dist_col[m-1][ERR_W-1:0];
                    pending_matches.insert(pending_matches.size(), hit);
                    predicted_hits++;
                end else begin
                    live_rows = PLEN_W'(cnt + 1);
                end
            end
            default: ;  // unused command code leaves everything as is
        endcase
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // offers one item after a random gap and holds it until accepted
    task automatic send_item(input apmc_in_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        update_edit_column(it);
        items_sent++;
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [PIDX_W-1:0] idx,
                            input logic [SYM_W-1:0] sym);
        apmc_in_t it;
        it.command       = cmd;
        it.pattern_index = idx;
        it.symbol        = sym;
        send_item(it);
    endtask

    // one text byte of the random part, now and then with a stray load or unused code
    task automatic send_text(input logic [SYM_W-1:0] sym);
        int pick;
        pick = $urandom_range(0, 59);
        if (pick == 0) begin
            send_cmd(CMD_UNUSED, PIDX_W'($urandom), SYM_W'($urandom));
        end else if (pick == 1) begin
            send_cmd(CMD_LOAD, PIDX_W'($urandom), SYM_W'($urandom));
            random_items++;
        end
        send_cmd(CMD_TEXT, PIDX_W'($urandom), sym);
        random_items++;
    endtask

    function automatic logic [SYM_W-1:0] pick_sym();
        if (narrow_alpha) return alpha[$urandom_range(0, 3)];
        return SYM_W'($urandom);
    endfunction

    // waits until every expected match is out and the row walk of any silent item is over
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_ERRORS:     lim_errors = val[ERR_W-1:0];
            REG_PATTERN_LENGTH: plen_reg   = val[PLEN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    function automatic dir_row_t item_row(input logic [CMD_W-1:0] cmd,
                                          input logic [PIDX_W-1:0] idx,
                                          input logic [SYM_W-1:0] sym);
        dir_row_t r;
        r = '0;
        r.item.command       = cmd;
        r.item.pattern_index = idx;
        r.item.symbol        = sym;
        return r;
    endfunction

    function automatic dir_row_t hit_row(input logic [CMD_W-1:0] cmd,
                                         input logic [PIDX_W-1:0] idx,
                                         input logic [SYM_W-1:0] sym,
                                         input logic [POS_W-1:0] pos,
                                         input logic [ERR_W-1:0] dist_val);
        dir_row_t r;
        r = item_row(cmd, idx, sym);
        r.typed             = 1'b1;
        r.want.end_position = pos;
        r.want.distance     = dist_val;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request, checking
    // ------------------------------------------------------------------
    initial begin : result_sink
        int        stall;
        apmc_out_t want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_req) begin
                // long hold-off so the output register fills and the input stalls
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            matches_seen++;
            if (pending_matches.size() == 0) begin
                $error("unexpected result: end_position %0d distance %0d",
                       m_data.end_position, m_data.distance);
                err_cnt++;
            end else begin
                want = pending_matches.pop_front();
                if (m_data.end_position !== want.end_position) begin
                    $error("end_position: expected %0d, got %0d",
                           want.end_position, m_data.end_position);
                    err_cnt++;
                end
                if (m_data.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, m_data.distance);
                    err_cnt++;
                end
            end
        end
    end

    // cycle budget for the whole run
    initial begin : watchdog
        wait (aresetn === 1'b0);
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t          dir_rows [$];
        int                hits_before, phase, sel, m_eff, n_occ, e, drain;
        bit                do_start;
        logic [PLEN_W-1:0] plen_val;
        logic [ERR_W-1:0]  err_val;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        phase     = 0;
        for (int i = 0; i < MAX_PAT; i++) pat_mem[i] = '0;
        lim_errors = 1;
        plen_reg   = 1;
        clear_column();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every slot gets a value first, so no text byte ever reads an unwritten slot
        for (int i = 0; i < MAX_PAT; i++)
            send_cmd(CMD_LOAD, PIDX_W'(i), SYM_W'($urandom_range(0, 255)));

        // directed table
        dir_rows.insert(dir_rows.size(), item_row(CMD_LOAD, 6'd0, 8'hFF));
        // text before any start runs from the reset column, one row, limit one
        dir_rows.insert(dir_rows.size(), hit_row(CMD_TEXT, 6'd0, 8'hFF, 32'd1, 6'd0));
        dir_rows.insert(dir_rows.size(), hit_row(CMD_TEXT, 6'd0, 8'h00, 32'd2, 6'd1));
        dir_rows.insert(dir_rows.size(), item_row(CMD_UNUSED, 6'h3F, 8'hAA));
        dir_rows.insert(dir_rows.size(), item_row(CMD_START, 6'h3F, 8'h00));
        dir_rows.insert(dir_rows.size(), hit_row(CMD_TEXT, 6'd0, 8'hFF, 32'd1, 6'd0));
        dir_rows.insert(dir_rows.size(), reg_row(REG_MAX_ERRORS, 7'd0));
        // every active row over the limit, count drops to zero
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'h00));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'hFF));
        dir_rows.insert(dir_rows.size(), item_row(CMD_LOAD, 6'd1, 8'h01));
        dir_rows.insert(dir_rows.size(), item_row(CMD_LOAD, 6'd2, 8'h80));
        dir_rows.insert(dir_rows.size(), item_row(CMD_LOAD, 6'd3, 8'h7F));
        // longer pattern mid-scan, column kept
        dir_rows.insert(dir_rows.size(), reg_row(REG_PATTERN_LENGTH, 7'd4));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'h2A, 8'h01));
        dir_rows.insert(dir_rows.size(), reg_row(REG_MAX_ERRORS, 7'd63));
        dir_rows.insert(dir_rows.size(), item_row(CMD_START, 6'd0, 8'hFF));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'hFF));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'h01));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'h80));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'h7F));
        // zero length clamps to one row
        dir_rows.insert(dir_rows.size(), reg_row(REG_PATTERN_LENGTH, 7'd0));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'h7F));
        // full register value clamps to the largest pattern
        dir_rows.insert(dir_rows.size(), reg_row(REG_PATTERN_LENGTH, 7'd127));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'hAA));
        dir_rows.insert(dir_rows.size(), item_row(CMD_START, 6'd0, 8'h00));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'hAA));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'h15, 8'h55));
        dir_rows.insert(dir_rows.size(), reg_row(REG_MAX_ERRORS, 7'd0));
        dir_rows.insert(dir_rows.size(), item_row(CMD_TEXT, 6'd0, 8'h55));

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_reg) begin
                settle();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                hits_before = predicted_hits;
                send_item(dir_rows[r].item);
                if (dir_rows[r].typed) begin
                    // typed value stands in for the prediction of this row
                    if (predicted_hits != hits_before)
                        pending_matches.delete(pending_matches.size() - 1);
                    pending_matches.insert(pending_matches.size(), dir_rows[r].want);
                end
            end
        end

        // random phases: new settings, maybe a new pattern, then edited copies in noise
        while (random_items < RANDOM_ITEMS) begin
            settle();
            phase++;
            no_idle = ($urandom_range(0, 4) == 0);
            sel     = $urandom_range(0, 19);
            if (phase == 3) begin
                // pressure phase: short pattern, many matches, long hold on the result side
                plen_val = 7'd3;
                no_idle  = 1'b1;
            end else if (sel < 15) begin
                plen_val = PLEN_W'($urandom_range(1, 8));
            end else if (sel < 18) begin
                plen_val = PLEN_W'($urandom_range(9, 24));
            end else begin
                case ($urandom_range(0, 3))
                    0:       plen_val = 7'd0;
                    1:       plen_val = 7'd64;
                    2:       plen_val = 7'd127;
                    default: plen_val = PLEN_W'($urandom_range(25, 127));
                endcase
            end
            m_eff = (plen_val < 1) ? 1 : ((plen_val > MAX_PAT) ? MAX_PAT : plen_val);
            case ($urandom_range(0, 9))
                0:       err_val = 6'd0;
                1:       err_val = 6'd63;
                default: err_val = ERR_W'($urandom_range(0, m_eff / 2 + 1));
            endcase
            if (phase == 3) err_val = 6'd1;

            if (phase == 3 || $urandom_range(0, 5) != 0) write_reg(REG_MAX_ERRORS, {1'b0, err_val});
            if (phase == 3 || $urandom_range(0, 5) != 0) write_reg(REG_PATTERN_LENGTH, plen_val);
            m_eff = used_length();

            narrow_alpha = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < 4; i++) alpha[i] = SYM_W'($urandom);

            if (phase == 3 || $urandom_range(0, 3) != 0) begin
                for (int i = 0; i < m_eff; i++) begin
                    send_cmd(CMD_LOAD, PIDX_W'(i), pick_sym());
                    random_items++;
                end
            end

            // without a start the old column carries on under the new settings
            do_start = (phase == 3) || ($urandom_range(0, 4) != 0);
            if (do_start) begin
                send_cmd(CMD_START, PIDX_W'($urandom), SYM_W'($urandom));
                random_items++;
            end

            if (phase == 3) hold_req = 1'b1;
            n_occ = (phase == 3) ? 12 : $urandom_range(1, 3);
            for (int o = 0; o < n_occ; o++) begin
                repeat ($urandom_range(0, 4)) send_text(pick_sym());
                for (int j = 0; j < m_eff; j++) begin
                    e = $urandom_range(0, 11);
                    if (e == 0) begin
                        send_text(pick_sym());          // substitution
                    end else if (e == 1) begin
                                                        // deletion
                    end else if (e == 2) begin
                        send_text(pick_sym());          // insertion
                        send_text(pat_mem[j]);
                    end else begin
                        send_text(pat_mem[j]);
                    end
                end
            end
        end

        // drain: all matches out, then let the last row walk finish
        s_valid <= 1'b0;
        drain = 0;
        while (pending_matches.size() != 0 && drain < DRAIN_CYCLES) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_matches.size() != 0) begin
            $error("%0d expected matches never arrived", pending_matches.size());
            err_cnt++;
        end

        $display("run covered %0d items (%0d random) over %0d phases and %0d register writes",
                 items_sent, random_items, phase, reg_writes);
        $display("%0d matches compared in %0d cycles, %0d errors",
                 matches_seen, cycle_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: approx_pattern_match_cutoff_unit.f
rtl/apmc_pkg.sv
rtl/apmc_cell.sv
rtl/approx_pattern_match_cutoff_unit.sv
sim/approx_pattern_match_cutoff_unit_tb.sv
